/* rtl/tst_pkg.sv */
// Package for the touch slot table: event codes, field widths and the
// request and response structs passed between the table and the top level.
// No dependencies.
`default_nettype none

package tst_pkg;

    localparam int TAG_W = 7;
    localparam int TAG_IN_W = 8;
    localparam int POS_W = 16;
    localparam int IDX_W = 4;
    localparam logic [TAG_W-1:0] TAG_MASK = 7'h7f;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_MOVE  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        logic                fire;
        t_op                 op;
        logic [TAG_IN_W-1:0] tag;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
    } t_req;

    typedef struct packed {
        logic [TAG_W-1:0] given_id;
        logic             table_full;
        logic             hit;
        logic [IDX_W-1:0] slot_index;
    } t_rsp;

endpackage

`default_nettype wire

/* rtl/tst_slot_table.sv */
// Slot storage, the combinational lookup and the registered update for one event.
// Depends on tst_pkg.
`default_nettype none

module tst_slot_table
    import tst_pkg::*;
#(
    parameter int TOUCH_SLOTS = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_req      i_req,
    output t_rsp      o_rsp
);

    localparam int SLOT_W = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;

    logic [TOUCH_SLOTS-1:0] r_busy, n_busy;
    logic [TAG_W-1:0]       r_tag [TOUCH_SLOTS];
    logic [POS_W-1:0]       r_x [TOUCH_SLOTS];
    logic [POS_W-1:0]       r_y [TOUCH_SLOTS];
    logic [TAG_W-1:0]       r_next_tag, n_next_tag;

    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              stop_found;
    logic [SLOT_W-1:0] stop_idx;
    logic              move_found;
    logic [SLOT_W-1:0] move_idx;

    logic              wr_tag;
    logic              wr_pos;
    logic [SLOT_W-1:0] wr_idx;
    t_rsp              rsp;

    // Priority searches: the lowest slot that qualifies wins.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        stop_found = 1'b0;
        stop_idx   = '0;
        move_found = 1'b0;
        move_idx   = '0;
        for (int i = 0; i < TOUCH_SLOTS; i++) begin
            if (!free_found && !r_busy[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
            if (!stop_found && r_busy[i] && ({1'b0, r_tag[i]} == i_req.tag)) begin
                stop_found = 1'b1;
                stop_idx   = SLOT_W'(i);
            end
            if (!move_found && r_busy[i] && (r_tag[i] == (i_req.tag[TAG_W-1:0] & TAG_MASK))) begin
                move_found = 1'b1;
                move_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_busy     = r_busy;
        n_next_tag = r_next_tag;
        wr_tag     = 1'b0;
        wr_pos     = 1'b0;
        wr_idx     = '0;
        rsp        = '0;
        case (i_req.op)
            OP_START: begin
                if (free_found) begin
                    wr_tag             = 1'b1;
                    wr_pos             = 1'b1;
                    wr_idx             = free_idx;
                    n_busy[free_idx]   = 1'b1;
                    n_next_tag         = (r_next_tag + TAG_W'(1)) & TAG_MASK;
                    rsp.given_id       = r_next_tag;
                    rsp.hit            = 1'b1;
                    rsp.slot_index     = IDX_W'(free_idx);
                end else begin
                    rsp.table_full = 1'b1;
                end
            end
            OP_STOP: begin
                if (stop_found) begin
                    n_busy[stop_idx] = 1'b0;
                    rsp.hit          = 1'b1;
                    rsp.slot_index   = IDX_W'(stop_idx);
                end
            end
            OP_MOVE: begin
                if (move_found) begin
                    wr_pos         = 1'b1;
                    wr_idx         = move_idx;
                    rsp.hit        = 1'b1;
                    rsp.slot_index = IDX_W'(move_idx);
                end
            end
            OP_CLEAR: begin
                n_busy     = '0;
                n_next_tag = '0;
            end
            default: begin
                n_busy = r_busy;
            end
        endcase
    end

    assign o_rsp = rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= '0;
            r_next_tag <= '0;
        end else if (i_req.fire) begin
            r_busy     <= n_busy;
            r_next_tag <= n_next_tag;
        end
    end

    // Stored ids and positions are only read behind a busy bit.
    always_ff @(posedge i_clk) begin
        if (i_req.fire && wr_tag) begin
            r_tag[wr_idx] <= r_next_tag;
        end
        if (i_req.fire && wr_pos) begin
            r_x[wr_idx] <= i_req.x;
            r_y[wr_idx] <= i_req.y;
        end
    end

endmodule

`default_nettype wire

/* rtl/touch_slot_table_core.sv */
// Touch slot table top level: input register, slot table and result register.
// An accepted beat waits in the input register; the table is updated and the
// result register loaded together. One beat per cycle, unless the output stalls.
// Reset is synchronous and active low; it frees every slot, zeroes the id counter
// and empties both the input and the result register.
// Depends on tst_pkg and tst_slot_table.
`default_nettype none

module touch_slot_table_core
    import tst_pkg::*;
#(
    parameter int TOUCH_SLOTS = 2
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [1:0]          i_op,
    input  wire logic [TAG_IN_W-1:0] i_touch_tag,
    input  wire logic [POS_W-1:0]    i_pos_x,
    input  wire logic [POS_W-1:0]    i_pos_y,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [TAG_W-1:0]         o_given_id,
    output logic                     o_table_full,
    output logic                     o_hit,
    output logic [IDX_W-1:0]         o_slot_index
);

    // Input register. A beat sits here until the result register can take
    // its outcome; the table state is updated at that same edge.
    logic                r_in_valid;
    t_op                 r_op;
    logic [TAG_IN_W-1:0] r_tag;
    logic [POS_W-1:0]    r_x;
    logic [POS_W-1:0]    r_y;

    // Result register.
    logic r_out_valid;
    t_rsp r_rsp;

    logic advance;
    logic in_take;
    t_req req;
    t_rsp rsp;

    // The stage moves forward when the result register is empty or its
    // beat is being taken this cycle.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op  <= t_op'(i_op);
            r_tag <= i_touch_tag;
            r_x   <= i_pos_x;
            r_y   <= i_pos_y;
        end
    end

    assign req.fire = r_in_valid && advance;
    assign req.op   = r_op;
    assign req.tag  = r_tag;
    assign req.x    = r_x;
    assign req.y    = r_y;

    tst_slot_table #(
        .TOUCH_SLOTS(TOUCH_SLOTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req.fire) begin
            r_rsp <= rsp;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_given_id   = r_rsp.given_id;
    assign o_table_full = r_rsp.table_full;
    assign o_hit        = r_rsp.hit;
    assign o_slot_index = r_rsp.slot_index;

    // A full table never reports a slot or an id.
    a_full_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_table_full |-> !o_hit && o_given_id == '0 && o_slot_index == '0)
        else $error("full result carries slot data");

    // A miss reports neither an index nor an id.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_slot_index == '0 && o_given_id == '0)
        else $error("miss result carries slot data");

    // The input side only stalls while a beat is held in the input register.
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a held beat");

    // A beat held in the input register while the output stalls is still there.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_op) && $stable(r_tag))
        else $error("held input beat lost");

endmodule

`default_nettype wire

/* sim/tb_touch_slot_table_core.sv */
// Self-checking testbench for touch_slot_table_core: directed table rows, then
// random touch traffic, with results checked against an in-bench slot table.
// Depends on tst_pkg and the RTL of touch_slot_table_core.
`default_nettype none

module tb_touch_slot_table_core;
    import tst_pkg::*;

    localparam int SLOTS = 2;
    localparam int NO_SLOT = -1;
    localparam int N_RANDOM = 1300;
    // No clear events are sent before this many random beats, so the id
    // counter has room to run past 127 and wrap.
    localparam int CLEAR_FREE_BEATS = 700;
    localparam int DRAIN_CYCLES = 8;

    // Receiver stall behaviors; one is picked for each stretch of cycles.
    localparam int STALL_NONE  = 0;
    localparam int STALL_SOME  = 1;
    localparam int STALL_HEAVY = 2;

    localparam t_rsp RSP_NONE = '0;
    localparam t_rsp RSP_FULL = t_rsp'{7'd0, 1'b1, 1'b0, 4'd0};

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_op = OP_START;
    logic [TAG_IN_W-1:0] i_touch_tag = '0;
    logic [POS_W-1:0]    i_pos_x = '0;
    logic [POS_W-1:0]    i_pos_y = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [TAG_W-1:0]    o_given_id;
    logic                o_table_full;
    logic                o_hit;
    logic [IDX_W-1:0]    o_slot_index;

    touch_slot_table_core #(
        .TOUCH_SLOTS(SLOTS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_op(i_op),
        .i_touch_tag(i_touch_tag),
        .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_given_id(o_given_id),
        .o_table_full(o_table_full),
        .o_hit(o_hit),
        .o_slot_index(o_slot_index)
    );

    always #4 i_clk = ~i_clk;

    // One row of the directed table. When has_rsp is set the expected result
    // is the one typed into the row; otherwise the slot table below decides.
    typedef struct {
        t_op                 op;
        logic [TAG_IN_W-1:0] tag;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        bit                  has_rsp;
        t_rsp                rsp;
    } t_dir_row;

    // The bench's own copy of the slot table and the id counter.
    logic                pred_busy [SLOTS];
    logic [TAG_W-1:0]    pred_tag [SLOTS];
    logic [POS_W-1:0]    pred_x [SLOTS];
    logic [POS_W-1:0]    pred_y [SLOTS];
    logic [TAG_W-1:0]    pred_next_id = '0;

    t_rsp pending_rsp_q [$];
    t_dir_row dir_rows [$];

    int n_errors = 0;
    int n_checked = 0;
    int n_hits = 0;
    int n_full = 0;
    int n_clears = 0;
    int n_wraps = 0;

    // Sender burst shaping: beats left in the current burst, idle cycles to
    // insert before the next beat.
    int burst_left = 1;
    int gap_left = 0;

    // Receiver stall shaping.
    int stall_mode = STALL_NONE;
    int stall_left = 0;

    // Applies one event to the bench's slot table and returns its result.
    // A stop compares the full 8-bit tag, so a tag above 127 finds nothing;
    // a move compares only the low 7 bits. Freed slots never match.
    function automatic t_rsp apply_touch_event(t_op op, logic [TAG_IN_W-1:0] tag,
                                               logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        t_rsp r;
        int   found;
        r = RSP_NONE;
        found = NO_SLOT;
        case (op)
            OP_START: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!pred_busy[i] && found == NO_SLOT) found = i;
                end
                if (found == NO_SLOT) begin
                    r.table_full = 1'b1;
                end else begin
                    pred_busy[found] = 1'b1;
                    pred_tag[found] = pred_next_id;
                    pred_x[found] = x;
                    pred_y[found] = y;
                    r.given_id = pred_next_id;
                    r.hit = 1'b1;
                    r.slot_index = IDX_W'(found);
                    if (pred_next_id == TAG_MASK) n_wraps++;
                    pred_next_id = pred_next_id + TAG_W'(1);
                end
            end
            OP_STOP: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (found == NO_SLOT && pred_busy[i] && {1'b0, pred_tag[i]} == tag)
                        found = i;
                end
                if (found != NO_SLOT) begin
                    pred_busy[found] = 1'b0;
                    r.hit = 1'b1;
                    r.slot_index = IDX_W'(found);
                end
            end
            OP_MOVE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (found == NO_SLOT && pred_busy[i] && pred_tag[i] == tag[TAG_W-1:0])
                        found = i;
                end
                if (found != NO_SLOT) begin
                    pred_x[found] = x;
                    pred_y[found] = y;
                    r.hit = 1'b1;
                    r.slot_index = IDX_W'(found);
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    pred_busy[i] = 1'b0;
                    pred_tag[i] = '0;
                    pred_x[i] = '0;
                    pred_y[i] = '0;
                end
                pred_next_id = '0;
                n_clears++;
            end
        endcase
        if (r.hit) n_hits++;
        if (r.table_full) n_full++;
        return r;
    endfunction

    function automatic t_dir_row mk_row(t_op op, logic [TAG_IN_W-1:0] tag,
                                        logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                        bit has_rsp, t_rsp rsp);
        t_dir_row row;
        row.op = op;
        row.tag = tag;
        row.x = x;
        row.y = y;
        row.has_rsp = has_rsp;
        row.rsp = rsp;
        return row;
    endfunction

    // Presents one beat at a falling edge, holds it until the rising edge at
    // which the input register takes it, then queues the expected result. Bursts and
    // gaps are drawn at random so that idle cycles land on every phase.
    task automatic send_beat(input t_dir_row row);
        t_rsp predicted;
        @(negedge i_clk);
        while (gap_left > 0) begin
            i_in_valid = 1'b0;
            gap_left--;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_op = row.op;
        i_touch_tag = row.tag;
        i_pos_x = row.x;
        i_pos_y = row.y;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_touch_event(row.op, row.tag, row.x, row.y);
        pending_rsp_q.push_back(row.has_rsp ? row.rsp : predicted);
        if (burst_left > 1) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            // About a third of the bursts follow on with no gap at all.
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
    endtask

    // Drops valid and holds off until every queued result has come back.
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    // The receiver picks a new stall behavior at the start of each random stretch: stretches
    // with no stall at all, light random stalling and heavy stalling.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
            stall_left = $urandom_range(4, 40);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE: i_out_stall = 1'b0;
            STALL_SOME: i_out_stall = ($urandom_range(0, 3) == 0);
            default:    i_out_stall = ($urandom_range(0, 3) != 0);
        endcase
    end

    // Every result beat taken by the receiver is compared with the oldest
    // expectation, one field at a time.
    t_rsp want_rsp;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_rsp_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, given_id %0d hit %0d",
                         $time, o_given_id, o_hit);
                n_errors++;
            end else begin
                want_rsp = pending_rsp_q.pop_front();
                n_checked++;
                check_field("given_id", int'(want_rsp.given_id), int'(o_given_id));
                check_field("table_full", int'(want_rsp.table_full), int'(o_table_full));
                check_field("hit", int'(want_rsp.hit), int'(o_hit));
                check_field("slot_index", int'(want_rsp.slot_index), int'(o_slot_index));
            end
        end
    end

    initial begin
        t_dir_row            row;
        int                  pick;
        logic [TAG_IN_W-1:0] live_tags [$];

        for (int i = 0; i < SLOTS; i++) begin
            pred_busy[i] = 1'b0;
            pred_tag[i] = '0;
            pred_x[i] = '0;
            pred_y[i] = '0;
        end

        // Directed table. Both slots are filled, the table overflows, tags
        // above 127 are tried on stop and move, a freed slot is probed, and a
        // clear brings the id counter back to zero.
        dir_rows.push_back(mk_row(OP_START, 8'h00, 16'h0000, 16'h0000, 1'b1,
                                  t_rsp'{7'd0, 1'b0, 1'b1, 4'd0}));
        dir_rows.push_back(mk_row(OP_START, 8'h00, 16'hffff, 16'hffff, 1'b1,
                                  t_rsp'{7'd1, 1'b0, 1'b1, 4'd1}));
        dir_rows.push_back(mk_row(OP_START, 8'h00, 16'h1234, 16'h4321, 1'b1, RSP_FULL));
        dir_rows.push_back(mk_row(OP_STOP,  8'd200, 16'h0000, 16'h0000, 1'b1, RSP_NONE));
        dir_rows.push_back(mk_row(OP_STOP,  8'h80, 16'h0000, 16'h0000, 1'b1, RSP_NONE));
        dir_rows.push_back(mk_row(OP_MOVE,  8'h80, 16'h1234, 16'habcd, 1'b1,
                                  t_rsp'{7'd0, 1'b0, 1'b1, 4'd0}));
        dir_rows.push_back(mk_row(OP_MOVE,  8'h81, 16'h8000, 16'h0001, 1'b1,
                                  t_rsp'{7'd0, 1'b0, 1'b1, 4'd1}));
        dir_rows.push_back(mk_row(OP_MOVE,  8'h05, 16'h0000, 16'hffff, 1'b1, RSP_NONE));
        dir_rows.push_back(mk_row(OP_STOP,  8'h00, 16'hffff, 16'h0000, 1'b1,
                                  t_rsp'{7'd0, 1'b0, 1'b1, 4'd0}));
        dir_rows.push_back(mk_row(OP_MOVE,  8'h00, 16'h5555, 16'haaaa, 1'b1, RSP_NONE));
        dir_rows.push_back(mk_row(OP_STOP,  8'h00, 16'h0000, 16'h0000, 1'b1, RSP_NONE));
        dir_rows.push_back(mk_row(OP_START, 8'hff, 16'h8000, 16'h7fff, 1'b1,
                                  t_rsp'{7'd2, 1'b0, 1'b1, 4'd0}));
        dir_rows.push_back(mk_row(OP_STOP,  8'h01, 16'h0000, 16'h0000, 1'b1,
                                  t_rsp'{7'd0, 1'b0, 1'b1, 4'd1}));
        dir_rows.push_back(mk_row(OP_START, 8'h00, 16'h7fff, 16'h8000, 1'b1,
                                  t_rsp'{7'd3, 1'b0, 1'b1, 4'd1}));
        dir_rows.push_back(mk_row(OP_START, 8'hff, 16'hffff, 16'hffff, 1'b1, RSP_FULL));
        dir_rows.push_back(mk_row(OP_MOVE,  8'h83, 16'h0f0f, 16'hf0f0, 1'b0, RSP_NONE));
        dir_rows.push_back(mk_row(OP_CLEAR, 8'hff, 16'hffff, 16'hffff, 1'b1, RSP_NONE));
        dir_rows.push_back(mk_row(OP_STOP,  8'h00, 16'h0000, 16'h0000, 1'b1, RSP_NONE));
        dir_rows.push_back(mk_row(OP_START, 8'h00, 16'haaaa, 16'h5555, 1'b1,
                                  t_rsp'{7'd0, 1'b0, 1'b1, 4'd0}));
        dir_rows.push_back(mk_row(OP_MOVE,  8'h00, 16'hffff, 16'h0000, 1'b1,
                                  t_rsp'{7'd0, 1'b0, 1'b1, 4'd0}));
        dir_rows.push_back(mk_row(OP_STOP,  8'hff, 16'h0000, 16'h0000, 1'b1, RSP_NONE));
        dir_rows.push_back(mk_row(OP_MOVE,  8'hff, 16'h0000, 16'h0000, 1'b1, RSP_NONE));
        dir_rows.push_back(mk_row(OP_START, 8'h7f, 16'h0001, 16'hfffe, 1'b0, RSP_NONE));
        dir_rows.push_back(mk_row(OP_STOP,  8'h7f, 16'h0000, 16'h0000, 1'b0, RSP_NONE));
        dir_rows.push_back(mk_row(OP_CLEAR, 8'h00, 16'h0000, 16'h0000, 1'b1, RSP_NONE));

        // Reset is held low from the start and released at a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) send_beat(dir_rows[i]);

        for (int n = 0; n < N_RANDOM; n++) begin
            // Halfway through, stop sending until the pipeline is empty.
            if (n == N_RANDOM / 2) wait_for_drain();

            live_tags.delete();
            for (int i = 0; i < SLOTS; i++) begin
                if (pred_busy[i]) live_tags.push_back({1'b0, pred_tag[i]});
            end

            row.x = POS_W'($urandom_range(0, 16'hffff));
            row.y = POS_W'($urandom_range(0, 16'hffff));
            row.tag = TAG_IN_W'($urandom_range(0, 8'hff));
            row.has_rsp = 1'b0;
            row.rsp = RSP_NONE;
            pick = $urandom_range(0, 999);

            if (n >= CLEAR_FREE_BEATS && pick < 5) begin
                row.op = OP_CLEAR;
            end else if (pick < 150) begin
                // Noise: any of start, stop and move with an arbitrary tag.
                row.op = t_op'($urandom_range(OP_START, OP_MOVE));
            end else if (pick < 550) begin
                row.op = OP_START;
            end else begin
                // Stops and moves mostly aim at an id that is live right now;
                // moves sometimes set the top tag bit, which must be ignored.
                row.op = (pick < 770) ? OP_STOP : OP_MOVE;
                if (live_tags.size() != 0 && $urandom_range(0, 7) != 0)
                    row.tag = live_tags[$urandom_range(0, live_tags.size() - 1)];
                else
                    row.tag = TAG_IN_W'($urandom_range(0, TAG_MASK));
                if (row.op == OP_MOVE && $urandom_range(0, 1))
                    row.tag[TAG_IN_W-1] = 1'b1;
            end
            send_beat(row);
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d result beats: %0d slot hits, %0d starts on a full table,",
                 n_checked, n_hits, n_full);
        $display("%0d clears, and the id counter wrapped %0d times.", n_clears, n_wraps);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // This limit is far beyond the length of a correct run and only catches a
    // hung handshake.
    initial begin
        #(8 * 400000);
        $display("Timeout with %0d results still outstanding.", pending_rsp_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/tst_pkg.sv
rtl/tst_slot_table.sv
rtl/touch_slot_table_core.sv
sim/tb_touch_slot_table_core.sv
